// ===== rtl/core/qkps_pkg.sv =====
`timescale 1ns / 1ps

package qkps_pkg;

   // Slot count and default widths
   localparam int NUM_SLOTS      = 5;
   localparam int SLOT_IDX_BITS  = $clog2(NUM_SLOTS);
   localparam int ID_BITS_DEF    = 16;
   localparam int COORD_BITS_DEF = 16;
   localparam int OUT_ID_BITS    = 16;
   localparam int MASK_BITS      = NUM_SLOTS;

   // Centre registers: whole pixels, widened to Q12.4 by the fraction bits
   localparam int CENTER_BITS   = 12;
   localparam int FRAC_BITS     = 4;
   localparam int CENTER_Q_BITS = CENTER_BITS + FRAC_BITS;
   localparam logic [CENTER_BITS-1:0] CENTER_X_RESET = 12'd320;
   localparam logic [CENTER_BITS-1:0] CENTER_Y_RESET = 12'd240;

   // Configuration register indexes
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CENTER_X = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CENTER_Y = 1'd1;

   // Command codes
   localparam int FUNC_BITS = 2;
   localparam logic [FUNC_BITS-1:0] FUNC_OFFER = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_DROP  = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_CLEAR = 2'd2;

   // Slot indexes
   localparam logic [SLOT_IDX_BITS-1:0] SLOT_CENTER = 3'd0;
   localparam logic [SLOT_IDX_BITS-1:0] SLOT_PP     = 3'd1;
   localparam logic [SLOT_IDX_BITS-1:0] SLOT_PN     = 3'd2;
   localparam logic [SLOT_IDX_BITS-1:0] SLOT_NP     = 3'd3;
   localparam logic [SLOT_IDX_BITS-1:0] SLOT_NN     = 3'd4;

   // Handshake between the request register and the slot bank
   typedef struct packed {
      logic valid;
   } stage_ctl_type;

endpackage

// ===== rtl/core/quadrant_key_point_select_unit.sv =====
`timescale 1ns / 1ps
// A result goes through the request register, then the slot update into the slot registers,
// which drive the result ports; a stall on the result side holds the item between them.
// Throughput: one item per cycle while the result side does not stall; set by the compare
// and update of the five slot registers, each item seeing the slots left by the one before it.
// Reset (synchronous, active high): all slots empty, centre at 320 x 240 pixels.
module quadrant_key_point_select_unit
   import qkps_pkg::*;
#(
   parameter int ID_BITS    = ID_BITS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wen,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CENTER_BITS-1:0]    csr_wdata,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [FUNC_BITS-1:0]      req_func,
   input  logic [ID_BITS-1:0]        req_feature_id,
   input  logic [COORD_BITS-1:0]     req_x_pos,
   input  logic [COORD_BITS-1:0]     req_y_pos,
   input  logic                      req_has_point,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [OUT_ID_BITS-1:0]    rsp_center_slot_id,
   output logic [OUT_ID_BITS-1:0]    rsp_quad_pp_id,
   output logic [OUT_ID_BITS-1:0]    rsp_quad_pn_id,
   output logic [OUT_ID_BITS-1:0]    rsp_quad_np_id,
   output logic [OUT_ID_BITS-1:0]    rsp_quad_nn_id,
   output logic [MASK_BITS-1:0]      rsp_valid_mask
);

   logic [CENTER_BITS-1:0] center_x_ff;
   logic [CENTER_BITS-1:0] center_y_ff;
   stage_ctl_type          stage_ctl;
   logic                   stage_take;
   logic [FUNC_BITS-1:0]   item_func;
   logic [ID_BITS-1:0]     item_id;
   logic [COORD_BITS-1:0]  item_x;
   logic [COORD_BITS-1:0]  item_y;
   logic                   item_has_point;

   // Centre registers
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= CENTER_X_RESET;
         center_y_ff <= CENTER_Y_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_CENTER_X: center_x_ff <= csr_wdata;
            CSR_CENTER_Y: center_y_ff <= csr_wdata;
            default:      center_x_ff <= center_x_ff;
         endcase
      end
   end

   qkps_req_reg #(
      .ID_BITS    (ID_BITS),
      .COORD_BITS (COORD_BITS)
   ) u_req_reg (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_feature_id (req_feature_id),
      .req_x_pos      (req_x_pos),
      .req_y_pos      (req_y_pos),
      .req_has_point  (req_has_point),
      .stage_take     (stage_take),
      .stage_ctl      (stage_ctl),
      .item_func      (item_func),
      .item_id        (item_id),
      .item_x         (item_x),
      .item_y         (item_y),
      .item_has_point (item_has_point)
   );

   qkps_slot_bank #(
      .ID_BITS    (ID_BITS),
      .COORD_BITS (COORD_BITS)
   ) u_slot_bank (
      .clock              (clock),
      .reset              (reset),
      .stage_ctl          (stage_ctl),
      .stage_take         (stage_take),
      .item_func          (item_func),
      .item_id            (item_id),
      .item_x             (item_x),
      .item_y             (item_y),
      .item_has_point     (item_has_point),
      .center_x           (center_x_ff),
      .center_y           (center_y_ff),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_center_slot_id (rsp_center_slot_id),
      .rsp_quad_pp_id     (rsp_quad_pp_id),
      .rsp_quad_pn_id     (rsp_quad_pn_id),
      .rsp_quad_np_id     (rsp_quad_np_id),
      .rsp_quad_nn_id     (rsp_quad_nn_id),
      .rsp_valid_mask     (rsp_valid_mask)
   );

endmodule

// ===== rtl/core/qkps_req_reg.sv =====
`timescale 1ns / 1ps

module qkps_req_reg
   import qkps_pkg::*;
#(
   parameter int ID_BITS    = ID_BITS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [FUNC_BITS-1:0]  req_func,
   input  logic [ID_BITS-1:0]    req_feature_id,
   input  logic [COORD_BITS-1:0] req_x_pos,
   input  logic [COORD_BITS-1:0] req_y_pos,
   input  logic                  req_has_point,
   input  logic                  stage_take,
   output stage_ctl_type         stage_ctl,
   output logic [FUNC_BITS-1:0]  item_func,
   output logic [ID_BITS-1:0]    item_id,
   output logic [COORD_BITS-1:0] item_x,
   output logic [COORD_BITS-1:0] item_y,
   output logic                  item_has_point
);

   logic                  valid_ff;
   logic                  valid_in;
   logic                  load;
   logic [FUNC_BITS-1:0]  func_ff;
   logic [ID_BITS-1:0]    id_ff;
   logic [COORD_BITS-1:0] x_ff;
   logic [COORD_BITS-1:0] y_ff;
   logic                  has_point_ff;

   // Stall only while the held item cannot move on
   assign req_stall = valid_ff & ~stage_take;
   assign load      = req_valid & ~req_stall;

   // Hold the item until the slot bank takes it
   always_comb begin
      valid_in = valid_ff;
      if (stage_take) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture payload on each input transfer
   always_ff @(posedge clock) begin
      if (load) begin
         func_ff      <= req_func;
         id_ff        <= req_feature_id;
         x_ff         <= req_x_pos;
         y_ff         <= req_y_pos;
         has_point_ff <= req_has_point;
      end
   end

   assign stage_ctl.valid = valid_ff;
   assign item_func       = func_ff;
   assign item_id         = id_ff;
   assign item_x          = x_ff;
   assign item_y          = y_ff;
   assign item_has_point  = has_point_ff;

endmodule

// ===== rtl/core/qkps_slot_bank.sv =====
`timescale 1ns / 1ps

module qkps_slot_bank
   import qkps_pkg::*;
#(
   parameter int ID_BITS    = ID_BITS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  stage_ctl_type          stage_ctl,
   output logic                   stage_take,
   input  logic [FUNC_BITS-1:0]   item_func,
   input  logic [ID_BITS-1:0]     item_id,
   input  logic [COORD_BITS-1:0]  item_x,
   input  logic [COORD_BITS-1:0]  item_y,
   input  logic                   item_has_point,
   input  logic [CENTER_BITS-1:0] center_x,
   input  logic [CENTER_BITS-1:0] center_y,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [OUT_ID_BITS-1:0] rsp_center_slot_id,
   output logic [OUT_ID_BITS-1:0] rsp_quad_pp_id,
   output logic [OUT_ID_BITS-1:0] rsp_quad_pn_id,
   output logic [OUT_ID_BITS-1:0] rsp_quad_np_id,
   output logic [OUT_ID_BITS-1:0] rsp_quad_nn_id,
   output logic [MASK_BITS-1:0]   rsp_valid_mask
);

   localparam int CW     = (COORD_BITS > CENTER_Q_BITS) ? COORD_BITS : CENTER_Q_BITS;
   localparam int ID_EXT = (ID_BITS > OUT_ID_BITS) ? ID_BITS : OUT_ID_BITS;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [ID_BITS-1:0]    slot_id_ff [NUM_SLOTS];
   logic [ID_BITS-1:0]    slot_id_in [NUM_SLOTS];
   logic [COORD_BITS-1:0] slot_x_ff  [NUM_SLOTS];
   logic [COORD_BITS-1:0] slot_x_in  [NUM_SLOTS];
   logic [COORD_BITS-1:0] slot_y_ff  [NUM_SLOTS];
   logic [COORD_BITS-1:0] slot_y_in  [NUM_SLOTS];
   logic [NUM_SLOTS-1:0]  slot_occ_ff;
   logic [NUM_SLOTS-1:0]  slot_occ_in;

   logic [CW-1:0]         cx;
   logic [CW-1:0]         cy;
   logic [CW-1:0]         new_x;
   logic [CW-1:0]         new_y;
   logic [CW-1:0]         new_dx;
   logic [CW-1:0]         new_dy;
   logic [CW-1:0]         new_cheb;
   logic [CW-1:0]         ctr_x;
   logic [CW-1:0]         ctr_y;
   logic [CW-1:0]         ctr_dx;
   logic [CW-1:0]         ctr_dy;
   logic [CW-1:0]         ctr_cheb;
   logic                  x_right;
   logic                  y_below;
   logic [SLOT_IDX_BITS-1:0] quad;
   logic [CW-1:0]         qs_x;
   logic [CW-1:0]         qs_y;
   logic [CW-1:0]         qs_dx;
   logic [CW-1:0]         qs_dy;
   logic [2*CW-1:0]       new_area;
   logic [2*CW-1:0]       qs_area;
   logic                  offer;
   logic                  take_center;
   logic                  take_quad;

   // Move the held item on when the result side is free
   assign stage_take = stage_ctl.valid & (~rsp_valid_ff | ~rsp_stall);

   // Centre in Q12.4 and both distances of the new feature
   assign cx    = CW'({center_x, {FRAC_BITS{1'b0}}});
   assign cy    = CW'({center_y, {FRAC_BITS{1'b0}}});
   assign new_x = CW'(item_x);
   assign new_y = CW'(item_y);
   assign x_right  = new_x >= cx;
   assign y_below  = new_y >= cy;
   assign new_dx   = x_right ? (new_x - cx) : (cx - new_x);
   assign new_dy   = y_below ? (new_y - cy) : (cy - new_y);
   assign new_cheb = (new_dx > new_dy) ? new_dx : new_dy;

   // Chebyshev distance of the feature held in the centre slot
   assign ctr_x    = CW'(slot_x_ff[SLOT_CENTER]);
   assign ctr_y    = CW'(slot_y_ff[SLOT_CENTER]);
   assign ctr_dx   = (ctr_x >= cx) ? (ctr_x - cx) : (cx - ctr_x);
   assign ctr_dy   = (ctr_y >= cy) ? (ctr_y - cy) : (cy - ctr_y);
   assign ctr_cheb = (ctr_dx > ctr_dy) ? ctr_dx : ctr_dy;

   // Pick the quadrant slot of the new feature
   always_comb begin
      case ({x_right, y_below})
         2'b11:   quad = SLOT_PP;
         2'b10:   quad = SLOT_PN;
         2'b01:   quad = SLOT_NP;
         default: quad = SLOT_NN;
      endcase
   end

   // Area of the new feature and of the one held in its quadrant slot
   assign qs_x     = CW'(slot_x_ff[quad]);
   assign qs_y     = CW'(slot_y_ff[quad]);
   assign qs_dx    = (qs_x >= cx) ? (qs_x - cx) : (cx - qs_x);
   assign qs_dy    = (qs_y >= cy) ? (qs_y - cy) : (cy - qs_y);
   assign new_area = new_dx * new_dy;
   assign qs_area  = qs_dx * qs_dy;

   assign offer       = (item_func == FUNC_OFFER) & item_has_point;
   assign take_center = offer & (~slot_occ_ff[SLOT_CENTER] | (new_cheb < ctr_cheb));
   assign take_quad   = offer & (~slot_occ_ff[quad] | (new_area > qs_area));

   // Work out the slot contents after this command
   always_comb begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
         slot_id_in[k] = slot_id_ff[k];
         slot_x_in[k]  = slot_x_ff[k];
         slot_y_in[k]  = slot_y_ff[k];
      end
      slot_occ_in = slot_occ_ff;
      case (item_func)
         FUNC_OFFER: begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
               if ((k == int'(SLOT_CENTER) && take_center) ||
                   (k == int'(quad) && take_quad)) begin
                  slot_id_in[k]  = item_id;
                  slot_x_in[k]   = item_x;
                  slot_y_in[k]   = item_y;
                  slot_occ_in[k] = 1'b1;
               end
            end
         end
         FUNC_DROP: begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
               if (slot_occ_ff[k] && slot_id_ff[k] == item_id) begin
                  slot_occ_in[k] = 1'b0;
               end
            end
         end
         FUNC_CLEAR: begin
            slot_occ_in = '0;
         end
         default: begin
            slot_occ_in = slot_occ_ff;
         end
      endcase
   end

   // Result valid: set on each step, drop on the output transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (stage_take) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         slot_occ_ff  <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (stage_take) begin
            slot_occ_ff <= slot_occ_in;
         end
      end
   end

   // Slot payload advances with the step
   always_ff @(posedge clock) begin
      if (stage_take) begin
         for (int k = 0; k < NUM_SLOTS; k++) begin
            slot_id_ff[k] <= slot_id_in[k];
            slot_x_ff[k]  <= slot_x_in[k];
            slot_y_ff[k]  <= slot_y_in[k];
         end
      end
   end

   // The slots themselves serve as the result register; empty slots read zero
   function automatic logic [OUT_ID_BITS-1:0] out_id(input logic [ID_BITS-1:0] id,
                                                     input logic occ);
      logic [ID_EXT-1:0] wide;
      wide = ID_EXT'(id);
      return occ ? wide[OUT_ID_BITS-1:0] : '0;
   endfunction

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_center_slot_id = out_id(slot_id_ff[SLOT_CENTER], slot_occ_ff[SLOT_CENTER]);
   assign rsp_quad_pp_id     = out_id(slot_id_ff[SLOT_PP], slot_occ_ff[SLOT_PP]);
   assign rsp_quad_pn_id     = out_id(slot_id_ff[SLOT_PN], slot_occ_ff[SLOT_PN]);
   assign rsp_quad_np_id     = out_id(slot_id_ff[SLOT_NP], slot_occ_ff[SLOT_NP]);
   assign rsp_quad_nn_id     = out_id(slot_id_ff[SLOT_NN], slot_occ_ff[SLOT_NN]);
   assign rsp_valid_mask     = slot_occ_ff;

   // Clear-all empties every slot
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (stage_take && item_func == FUNC_CLEAR) |=> (slot_occ_ff == '0))
      else $error("slots still occupied after clear");

   // After an offer with a point the centre slot and at least one quadrant slot are occupied
   a_offer_fills: assert property (@(posedge clock) disable iff (reset)
      (stage_take && offer) |=> (slot_occ_ff[SLOT_CENTER] && slot_occ_ff[NUM_SLOTS-1:1] != '0))
      else $error("offer left centre or quadrants empty");

   // Slots fill only through an offer
   a_fill_only_on_offer: assert property (@(posedge clock) disable iff (reset)
      !(stage_take && offer) |=> ((slot_occ_ff & ~$past(slot_occ_ff)) == '0))
      else $error("slot filled without an offer");

   // Slot occupancy changes only on a step, so it holds while the result waits
   a_hold_while_stalled: assert property (@(posedge clock) disable iff (reset)
      !stage_take |=> $stable(slot_occ_ff))
      else $error("slot state changed without a step");

endmodule
